@@ rtl/assert_macros.svh @@
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/pcptf_pkg.sv @@
`default_nettype none
package pcptf_pkg;

  localparam int FRAC_BITS_DEF    = 16;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_LEN         = 24;

  localparam int CFG_W = 31;
  localparam int CW    = 40;   // CORDIC datapath width
  localparam int MW    = 50;   // 32x18 product
  localparam int SW    = 42;   // square root operand
  localparam int SQ_STAGES = 21;

  localparam logic [1:0] REG_MIN_ABS  = 2'd0;
  localparam logic [1:0] REG_MAX_ABS  = 2'd1;
  localparam logic [1:0] REG_MIN_DIST = 2'd2;

  localparam logic signed [CW-1:0] PI_Q30      = CW'(64'sd3373259426);
  localparam logic signed [CW-1:0] HALF_PI_Q30 = CW'(64'sd1686629713);
  localparam logic signed [CW-1:0] GAIN_INV    = CW'(64'sd652032874);
  localparam logic signed [17:0]   HEAD_ONE    = 18'sd65536;
  localparam logic [20:0]          RANGE_MAX   = 21'd1048575;

  typedef struct packed {
    logic               action;
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
  } item_t;

  typedef struct packed {
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
    logic [19:0]        range_to_robot;
  } result_t;

  function automatic logic signed [CW-1:0] atan_q30(input int i);
    logic signed [CW-1:0] v;
    case (i)
      0:  v = CW'(64'sd843314857);
      1:  v = CW'(64'sd497837830);
      2:  v = CW'(64'sd263043837);
      3:  v = CW'(64'sd133525159);
      4:  v = CW'(64'sd67021687);
      5:  v = CW'(64'sd33543516);
      6:  v = CW'(64'sd16775851);
      7:  v = CW'(64'sd8388437);
      8:  v = CW'(64'sd4194283);
      9:  v = CW'(64'sd2097149);
      default: v = CW'(64'sd1048576 >>> (i - 10));
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

@@ rtl/pcptf_if.sv @@
`default_nettype none
interface pcptf_item_if;
  import pcptf_pkg::*;
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pcptf_result_if;
  import pcptf_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/point_cloud_pose_transform_filter_top.sv @@
// channel   dir  payload
// item      in   action, pose, quaternion, point
// result    out  world_x, world_y, range_to_robot
// cfg       in   cfg_we, cfg_index, cfg_data
//
// One item per cycle unless a held result stalls the pipeline; CORDIC_STEPS is
// capped at 24 for the two CORDIC passes, and the square root resolves one bit per stage.
// Synchronous reset clears all stage valid bits, resets pose state and loads config defaults.
// A held result freezes the whole pipeline; item.ready drops until it moves.
`default_nettype none
module point_cloud_pose_transform_filter_top #(
  parameter int FRAC_BITS    = pcptf_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = pcptf_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  pcptf_item_if.sink                   item,
  pcptf_result_if.source               result,
  input  wire logic                    cfg_we,
  input  wire logic [1:0]              cfg_index,
  input  wire logic [pcptf_pkg::CFG_W-1:0] cfg_data
);
  import pcptf_pkg::*;
  `include "assert_macros.svh"

  localparam int N  = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
  localparam int NF = 2 * N + 5;
  localparam int NB = 8 + SQ_STAGES;

  localparam logic [63:0] MIN_ABS_RST  = ((64'd1 << FRAC_BITS) + 64'd50) / 64'd100;
  localparam logic [63:0] MAX_ABS_RST  = 64'd10 << FRAC_BITS;
  localparam logic [63:0] MIN_DIST_RST = ((64'd11 << FRAC_BITS) + 64'd50) / 64'd100;

  typedef struct packed {
    logic                 vld;
    item_t                it;
    logic signed [31:0]   p0, p1, p2, p3;
    logic                 deg;
    logic                 flip;
    logic signed [CW-1:0] x, y, z;
    logic signed [17:0]   sn, cs;
  } front_t;

  typedef struct packed {
    logic                 vld;
    logic signed [31:0]   rbx, rby;
    logic signed [MW-1:0] m0, m1, m2, m3;
    logic signed [35:0]   rx, ry;
    logic signed [31:0]   wx, wy;
    logic signed [32:0]   dx, dy;
    logic [32:0]          adx, ady;
    logic                 big;
    logic [SW-1:0]        v, r;
  } back_t;

  logic [15:0]        min_abs;
  logic [30:0]        max_abs;
  logic [19:0]        min_dist;
  logic signed [31:0] robot_x, robot_y;
  logic signed [17:0] heading_sine, heading_cosine;

  front_t fr [NF];
  front_t fr_next [NF];
  back_t  bk [NB];
  back_t  bk_next [NB];
  logic   en;

  assign en          = !bk[NB-1].vld || result.ready;
  assign item.ready  = en;
  assign result.valid = bk[NB-1].vld;
  assign result.data.world_x = bk[NB-1].wx;
  assign result.data.world_y = bk[NB-1].wy;
  assign result.data.range_to_robot = bk[NB-1].r[19:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      min_abs  <= MIN_ABS_RST[15:0];
      max_abs  <= MAX_ABS_RST[30:0];
      min_dist <= MIN_DIST_RST[19:0];
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MIN_ABS:  min_abs  <= cfg_data[15:0];
        REG_MAX_ABS:  max_abs  <= cfg_data[30:0];
        REG_MIN_DIST: min_dist <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  // front: quaternion products, prep, vectoring, fold, rotation, heading
  always_comb begin
    logic signed [CW-1:0] a, b;
    fr_next[0]     = fr[0];
    fr_next[0].vld = item.valid;
    fr_next[0].it  = item.data;

    fr_next[1]    = fr[0];
    fr_next[1].p0 = fr[0].it.quat_w * fr[0].it.quat_z;
    fr_next[1].p1 = fr[0].it.quat_x * fr[0].it.quat_y;
    fr_next[1].p2 = fr[0].it.quat_y * fr[0].it.quat_y;
    fr_next[1].p3 = fr[0].it.quat_z * fr[0].it.quat_z;

    a = (CW'(fr[1].p0) + CW'(fr[1].p1)) <<< 1;
    b = (CW'(1) <<< 28) - ((CW'(fr[1].p2) + CW'(fr[1].p3)) <<< 1);
    fr_next[2]      = fr[1];
    fr_next[2].deg  = (a == '0) && (b == '0);
    fr_next[2].flip = 1'b0;
    if (b < 0) begin
      fr_next[2].x = -b;
      fr_next[2].y = -a;
      fr_next[2].z = (a >= 0) ? PI_Q30 : -PI_Q30;
    end else begin
      fr_next[2].x = b;
      fr_next[2].y = a;
      fr_next[2].z = '0;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_vec
    always_comb begin
      front_t s;
      s = fr[2+i];
      if (s.y >= 0) begin
        s.x = fr[2+i].x + (fr[2+i].y >>> i);
        s.y = fr[2+i].y - (fr[2+i].x >>> i);
        s.z = fr[2+i].z + atan_q30(i);
      end else begin
        s.x = fr[2+i].x - (fr[2+i].y >>> i);
        s.y = fr[2+i].y + (fr[2+i].x >>> i);
        s.z = fr[2+i].z - atan_q30(i);
      end
      fr_next[3+i] = s;
    end
  end

  always_comb begin
    front_t s;
    s = fr[2+N];
    if (s.z > HALF_PI_Q30) begin
      s.z = fr[2+N].z - PI_Q30;
      s.flip = 1'b1;
    end else if (s.z < -HALF_PI_Q30) begin
      s.z = fr[2+N].z + PI_Q30;
      s.flip = 1'b1;
    end
    s.x = GAIN_INV;
    s.y = '0;
    fr_next[3+N] = s;
  end

  for (genvar i = 0; i < N; i++) begin : g_rot
    always_comb begin
      front_t s;
      s = fr[3+N+i];
      if (s.z >= 0) begin
        s.x = fr[3+N+i].x - (fr[3+N+i].y >>> i);
        s.y = fr[3+N+i].y + (fr[3+N+i].x >>> i);
        s.z = fr[3+N+i].z - atan_q30(i);
      end else begin
        s.x = fr[3+N+i].x + (fr[3+N+i].y >>> i);
        s.y = fr[3+N+i].y - (fr[3+N+i].x >>> i);
        s.z = fr[3+N+i].z + atan_q30(i);
      end
      fr_next[4+N+i] = s;
    end
  end

  function automatic logic signed [17:0] head_q(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] r;
    r = (v + (CW'(1) <<< 13)) >>> 14;
    if (r > CW'(HEAD_ONE)) return HEAD_ONE;
    if (r < -CW'(HEAD_ONE)) return -HEAD_ONE;
    return r[17:0];
  endfunction

  always_comb begin
    front_t s;
    s = fr[NF-2];
    if (s.deg) begin
      s.sn = '0;
      s.cs = HEAD_ONE;
    end else if (s.flip) begin
      s.sn = head_q(-fr[NF-2].y);
      s.cs = head_q(-fr[NF-2].x);
    end else begin
      s.sn = head_q(fr[NF-2].y);
      s.cs = head_q(fr[NF-2].x);
    end
    fr_next[NF-1] = s;
  end

  // commit: poses update state here, points read it here
  always_ff @(posedge clk) begin
    if (rst) begin
      robot_x        <= '0;
      robot_y        <= '0;
      heading_sine   <= '0;
      heading_cosine <= HEAD_ONE;
    end else if (en && fr[NF-1].vld && !fr[NF-1].it.action) begin
      robot_x        <= fr[NF-1].it.pose_x;
      robot_y        <= fr[NF-1].it.pose_y;
      heading_sine   <= fr[NF-1].sn;
      heading_cosine <= fr[NF-1].cs;
    end
  end

  always_comb begin
    logic [32:0] mx, my;
    logic        ok;
    logic signed [32:0] px, py;
    px = 33'(fr[NF-1].it.point_x);
    py = 33'(fr[NF-1].it.point_y);
    mx = (px < 0) ? 33'(-px) : 33'(px);
    my = (py < 0) ? 33'(-py) : 33'(py);
    ok = (mx >= 33'(min_abs)) && (mx <= 33'(max_abs)) &&
         (my >= 33'(min_abs)) && (my <= 33'(max_abs));
    bk_next[0]     = bk[0];
    bk_next[0].vld = fr[NF-1].vld && fr[NF-1].it.action && ok;
    bk_next[0].rbx = robot_x;
    bk_next[0].rby = robot_y;
    bk_next[0].m0  = fr[NF-1].it.point_x * heading_sine;
    bk_next[0].m1  = fr[NF-1].it.point_y * heading_cosine;
    bk_next[0].m2  = fr[NF-1].it.point_y * heading_sine;
    bk_next[0].m3  = fr[NF-1].it.point_x * heading_cosine;
  end

  function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
    if (v > 37'sd2147483647) return 32'sh7fffffff;
    if (v < -37'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  always_comb begin
    logic signed [MW+1:0] sx, sy;
    sx = 52'(bk[0].m0) + 52'(bk[0].m1) + 52'sd32768;
    sy = 52'(bk[0].m2) - 52'(bk[0].m3) + 52'sd32768;
    bk_next[1]    = bk[0];
    bk_next[1].rx = 36'(sx >>> 16);
    bk_next[1].ry = 36'(sy >>> 16);

    bk_next[2]    = bk[1];
    bk_next[2].wx = sat32(37'(bk[1].rx) + 37'(bk[1].rbx));
    bk_next[2].wy = sat32(37'(bk[1].ry) + 37'(bk[1].rby));

    bk_next[3]    = bk[2];
    bk_next[3].dx = 33'(bk[2].rbx) - 33'(bk[2].wx);
    bk_next[3].dy = 33'(bk[2].rby) - 33'(bk[2].wy);

    bk_next[4]     = bk[3];
    bk_next[4].adx = (bk[3].dx < 0) ? 33'(-bk[3].dx) : 33'(bk[3].dx);
    bk_next[4].ady = (bk[3].dy < 0) ? 33'(-bk[3].dy) : 33'(bk[3].dy);

    bk_next[5]     = bk[4];
    bk_next[5].big = (bk[4].adx > 33'(RANGE_MAX)) || (bk[4].ady > 33'(RANGE_MAX));
    bk_next[5].v   = SW'(bk[4].adx[19:0] * bk[4].adx[19:0]);
    bk_next[5].r   = SW'(bk[4].ady[19:0] * bk[4].ady[19:0]);

    bk_next[6]   = bk[5];
    bk_next[6].v = bk[5].big ? '0 : bk[5].v + bk[5].r;
    bk_next[6].r = '0;
  end

  for (genvar j = 0; j < SQ_STAGES; j++) begin : g_sqrt
    localparam logic [SW-1:0] BIT = SW'(1) << (2 * (SQ_STAGES - 1 - j));
    always_comb begin
      back_t s;
      s = bk[6+j];
      if (bk[6+j].v >= bk[6+j].r + BIT) begin
        s.v = bk[6+j].v - (bk[6+j].r + BIT);
        s.r = (bk[6+j].r >> 1) + BIT;
      end else begin
        s.r = bk[6+j].r >> 1;
      end
      bk_next[7+j] = s;
    end
  end

  always_comb begin
    logic [20:0] rng;
    back_t s;
    s   = bk[NB-2];
    rng = bk[NB-2].big ? RANGE_MAX + 21'd1 : bk[NB-2].r[20:0];
    s.vld = bk[NB-2].vld && (rng > {1'b0, min_dist});
    s.r   = (rng > RANGE_MAX) ? SW'(RANGE_MAX) : SW'(rng);
    bk_next[NB-1] = s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NF; i++) fr[i].vld <= 1'b0;
      for (int i = 0; i < NB; i++) bk[i].vld <= 1'b0;
    end else if (en) begin
      for (int i = 0; i < NF; i++) fr[i] <= fr_next[i];
      for (int i = 0; i < NB; i++) bk[i] <= bk_next[i];
    end
  end

  `ASSERT_CLK(a_accept_enters, item.valid && item.ready |=> fr[0].vld, "transfer not captured")
  `ASSERT_CLK(a_pose_no_result, en && fr[NF-1].vld && !fr[NF-1].it.action |=> !bk[0].vld,
    "pose produced a point")
  `ASSERT_CLK(a_head_range, heading_cosine <= HEAD_ONE && heading_cosine >= -HEAD_ONE,
    "cosine out of range")
  `ASSERT_CLK(a_stall_freeze, !en |=> $stable(bk[0].m0) && $stable(fr[0].it),
    "pipeline moved during stall")

endmodule
`default_nettype wire

@@ tb/sv/point_cloud_pose_transform_filter_top_tb.sv @@
`timescale 1ns / 100ps

module point_cloud_pose_transform_filter_top_tb;
  import pcptf_pkg::*;

  class obstacle_board;
    longint robot_x, robot_y, head_sin, head_cos;
    longint min_abs, max_abs, min_dist;
    result_t expected_obstacles[$];
    int errors;
    longint atan_tab[16] = '{843314857, 497837830, 263043837, 133525159, 67021687,
                             33543516, 16775851, 8388437, 4194283, 2097149, 1048576,
                             524288, 262144, 131072, 65536, 32768};

    function new();
      robot_x = 0;
      robot_y = 0;
      head_sin = 0;
      head_cos = 65536;
      min_abs = 655;
      max_abs = 655360;
      min_dist = 7209;
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, longint val);
      case (idx)
        REG_MIN_ABS:  min_abs = val & 64'hFFFF;
        REG_MAX_ABS:  max_abs = val & 64'h7FFF_FFFF;
        REG_MIN_DIST: min_dist = val & 64'hF_FFFF;
        default: ;
      endcase
    endfunction

    function longint clamp_one(longint v);
      longint r;
      r = (v + 64'sd8192) >>> 14;
      if (r > 65536) r = 65536;
      if (r < -65536) r = -65536;
      return r;
    endfunction

    function void set_heading(longint a, longint b);
      longint vx, vy, z, cx, cy, t;
      bit flip;
      vx = b;
      vy = a;
      z = 0;
      flip = 0;
      if (a == 0 && b == 0) begin
        head_sin = 0;
        head_cos = 65536;
        return;
      end
      if (vx < 0) begin
        z = (vy >= 0) ? 64'sd3373259426 : -64'sd3373259426;
        vx = -vx;
        vy = -vy;
      end
      for (int i = 0; i < 16; i++) begin
        t = vx;
        if (vy >= 0) begin
          vx += vy >>> i; vy -= t >>> i; z += atan_tab[i];
        end else begin
          vx -= vy >>> i; vy += t >>> i; z -= atan_tab[i];
        end
      end
      if (z > 64'sd1686629713) begin
        z -= 64'sd3373259426; flip = 1;
      end else if (z < -64'sd1686629713) begin
        z += 64'sd3373259426; flip = 1;
      end
      cx = 652032874;
      cy = 0;
      for (int i = 0; i < 16; i++) begin
        t = cx;
        if (z >= 0) begin
          cx -= cy >>> i; cy += t >>> i; z -= atan_tab[i];
        end else begin
          cx += cy >>> i; cy -= t >>> i; z += atan_tab[i];
        end
      end
      if (flip) begin
        cx = -cx; cy = -cy;
      end
      head_cos = clamp_one(cx);
      head_sin = clamp_one(cy);
    endfunction

    function longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint isqrt(longint v);
      longint r, b;
      r = 0;
      b = 64'sd1 <<< 62;
      while (b > v) b = b >>> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b; r = (r >>> 1) + b;
        end else r = r >>> 1;
        b = b >>> 2;
      end
      return r;
    endfunction

    function bit coord_ok(longint c);
      longint m;
      m = (c < 0) ? -c : c;
      return m >= min_abs && m <= max_abs;
    endfunction

    function void note_item(item_t it);
      longint qw, qx, qy, qz, px, py, wx, wy, dx, dy, rng;
      result_t r;
      if (!it.action) begin
        qw = it.quat_w; qx = it.quat_x; qy = it.quat_y; qz = it.quat_z;
        robot_x = it.pose_x;
        robot_y = it.pose_y;
        set_heading(2 * (qw * qz + qx * qy), (64'sd1 <<< 28) - 2 * (qy * qy + qz * qz));
        return;
      end
      px = it.point_x;
      py = it.point_y;
      if (!coord_ok(px) || !coord_ok(py)) return;
      wx = sat32(((px * head_sin + py * head_cos + 32768) >>> 16) + robot_x);
      wy = sat32(((py * head_sin - px * head_cos + 32768) >>> 16) + robot_y);
      dx = robot_x - wx; if (dx < 0) dx = -dx;
      dy = robot_y - wy; if (dy < 0) dy = -dy;
      if (dx > 1048575 || dy > 1048575) rng = 1048576;
      else rng = isqrt(dx * dx + dy * dy);
      if (rng <= min_dist) return;
      if (rng > 1048575) rng = 1048575;
      r.world_x = wx[31:0];
      r.world_y = wy[31:0];
      r.range_to_robot = rng[19:0];
      expected_obstacles.push_back(r);
    endfunction

    function void check_obstacle(result_t got);
      result_t exp;
      if (expected_obstacles.size() == 0) begin
        $display("%0t: unexpected transfer %h", $time, got);
        errors++;
        return;
      end
      exp = expected_obstacles.pop_front();
      if (got.world_x !== exp.world_x) begin
        $display("%0t: world_x exp %0d got %0d", $time, exp.world_x, got.world_x);
        errors++;
      end
      if (got.world_y !== exp.world_y) begin
        $display("%0t: world_y exp %0d got %0d", $time, exp.world_y, got.world_y);
        errors++;
      end
      if (got.range_to_robot !== exp.range_to_robot) begin
        $display("%0t: range exp %0d got %0d", $time, exp.range_to_robot, got.range_to_robot);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [1:0] cfg_index = REG_MIN_ABS;
  logic [CFG_W-1:0] cfg_data = '0;
  bit quiet = 0;
  bit hold_req = 0;
  obstacle_board board = new();

  pcptf_item_if item_if();
  pcptf_result_if result_if();

  point_cloud_pose_transform_filter_top dut (
    .clk(clk), .rst(rst), .item(item_if), .result(result_if),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  initial begin
    #2000000;
    $display("point_cloud_pose_transform_filter_top test failed");
    $finish;
  end

  initial begin
    result_if.ready = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        result_if.ready <= 0;
        repeat (400) @(negedge clk);
        hold_req = 0;
      end else result_if.ready <= quiet || $urandom_range(99) >= 7;
      @(negedge clk);
    end
  end

  always @(posedge clk)
    if (!rst && result_if.valid && result_if.ready) board.check_obstacle(result_if.data);

  task automatic send_item(input item_t it);
    while (!quiet && $urandom_range(99) < 7) begin
      item_if.valid <= 0;
      @(negedge clk);
    end
    item_if.valid <= 1;
    item_if.data <= it;
    do @(posedge clk); while (!item_if.ready);
    board.note_item(it);
    @(negedge clk);
  endtask

  task automatic drain();
    item_if.valid <= 0;
    while (board.expected_obstacles.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input longint val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val[CFG_W-1:0];
    board.write_reg(idx, val);
    @(negedge clk);
    cfg_we <= 0;
  endtask

  function automatic item_t noise_item(bit act);
    item_t it;
    it.action = act;
    it.pose_x = $urandom; it.pose_y = $urandom;
    it.quat_w = $signed(16'($urandom_range(32768))) - 16'sd16384;
    it.quat_x = $signed(16'($urandom_range(32768))) - 16'sd16384;
    it.quat_y = $signed(16'($urandom_range(32768))) - 16'sd16384;
    it.quat_z = $signed(16'($urandom_range(32768))) - 16'sd16384;
    it.point_x = $urandom; it.point_y = $urandom;
    return it;
  endfunction

  function automatic logic [31:0] pick_coord();
    longint lo, hi, m;
    lo = board.min_abs;
    hi = board.max_abs;
    if (lo > hi || $urandom_range(9) == 0) return $urandom;
    if (hi - lo > 64'd8000000 && $urandom_range(3) != 0) hi = lo + 64'd4000000;
    m = lo + longint'($urandom_range(32'(hi - lo)));
    return $urandom_range(1) ? 32'(-m) : 32'(m);
  endfunction

  function automatic item_t make_item(bit act);
    item_t it;
    it = noise_item(act);
    if (act) begin
      it.point_x = pick_coord();
      it.point_y = pick_coord();
    end else if ($urandom_range(3) != 0) begin
      it.pose_x = $signed(32'($urandom_range(8000000))) - 32'sd4000000;
      it.pose_y = $signed(32'($urandom_range(8000000))) - 32'sd4000000;
    end
    return it;
  endfunction

  task automatic pose(input longint x, input longint y, input logic signed [15:0] w,
                      input logic signed [15:0] qx, input logic signed [15:0] qy,
                      input logic signed [15:0] qz);
    item_t it;
    it = noise_item(0);
    it.pose_x = x; it.pose_y = y;
    it.quat_w = w; it.quat_x = qx; it.quat_y = qy; it.quat_z = qz;
    send_item(it);
  endtask

  task automatic point(input longint x, input longint y);
    item_t it;
    it = noise_item(1);
    it.point_x = x; it.point_y = y;
    send_item(it);
  endtask

  task automatic random_run(input int n);
    for (int i = 0; i < n; i++) send_item(make_item($urandom_range(9) != 0));
  endtask

  initial begin
    item_if.valid = 0;
    item_if.data = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // defaults, identity heading
    point(655, -655);
    point(654, 70000);
    point(655360, -655360);
    point(655361, 1000);
    point(3000, 3000);
    point(-32'sd2147483648, 32'sd2147483647);
    // degenerate quaternion, heading of pi, zero heading, beyond half pi, near minus half pi
    pose(100000, -100000, 0, 0, 0, 0);
    point(200000, 300000);
    pose(-32'sd2147483648, 32'sd2147483647, 0, 0, 0, 16384);
    point(500000, -500000);
    pose(0, 0, 0, 16384, 0, -16384);
    point(-400000, 400000);
    pose(0, 0, -16384, 0, 0, 0);
    point(100000, 200000);
    pose(50000, 50000, 16384, 16384, 16384, 16384);
    point(655360, 655360);
    pose(0, 0, -16384, -16384, -16384, -16384);
    point(-655360, -655);
    pose(32'sd2147483647, -32'sd2147483648, 11585, 0, 0, -11585);
    point(600000, 600000);
    random_run(280);

    drain();
    write_reg(REG_MIN_ABS, 0);
    write_reg(REG_MAX_ABS, 64'h7FFF_FFFF);
    write_reg(REG_MIN_DIST, 0);
    point(0, 0);
    point(32'sd2147483647, -32'sd2147483647);
    pose(32'sd2147483647, 32'sd2147483647, 16384, 0, 0, 0);
    point(32'sd2147483647, 32'sd2147483647);
    random_run(100);
    hold_req = 1;
    random_run(200);

    drain();
    write_reg(REG_MIN_ABS, 65535);
    write_reg(REG_MAX_ABS, 65535 * 16);
    write_reg(REG_MIN_DIST, 64'hF_FFFF);
    random_run(150);

    drain();
    write_reg(REG_MIN_ABS, 5000);
    write_reg(REG_MAX_ABS, 4000);
    write_reg(REG_MIN_DIST, 100);
    random_run(100);

    drain();
    write_reg(REG_MIN_ABS, $urandom_range(2000));
    write_reg(REG_MAX_ABS, 100000 + $urandom_range(2000000));
    write_reg(REG_MIN_DIST, $urandom_range(50000));
    quiet = 1;
    random_run(300);
    quiet = 0;
    random_run(100);

    drain();
    write_reg(REG_MIN_ABS, 655);
    write_reg(REG_MAX_ABS, 655360);
    write_reg(REG_MIN_DIST, 7209);
    random_run(400);

    drain();
    if (board.errors == 0) $display("point_cloud_pose_transform_filter_top test passed");
    else $display("point_cloud_pose_transform_filter_top test failed");
    $finish;
  end
endmodule

@@ point_cloud_pose_transform_filter_top.f @@
+incdir+rtl
rtl/pcptf_pkg.sv
rtl/pcptf_if.sv
rtl/point_cloud_pose_transform_filter_top.sv
tb/sv/point_cloud_pose_transform_filter_top_tb.sv
